/* design/idws_pkg.sv */
// Shared types, constants and fixed-point helpers for the inertial drag tracker.
package idws_pkg;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_MOVE    = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_NONE    = 2'd3
    } req_kind_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FRICTION    = 3'd0;
    localparam logic [2:0] CFG_INPUT_ACCEL = 3'd1;
    localparam logic [2:0] CFG_SNAP_ACCEL  = 3'd2;
    localparam logic [2:0] CFG_SPACING_X   = 3'd3;
    localparam logic [2:0] CFG_SPACING_Y   = 3'd4;

    localparam logic [15:0] FRICTION_RESET    = 16'd6554;
    localparam logic [15:0] INPUT_ACCEL_RESET = 16'd13107;
    localparam logic [15:0] SNAP_ACCEL_RESET  = 16'd328;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic signed [31:0] SNAP_SPEED_LIMIT = 32'sd6554;
    localparam logic signed [67:0] STEP_LIMIT = 68'sd1099511627776;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_T_MUL,
        ST_T_POS,
        ST_T_MODST,
        ST_T_DIV,
        ST_T_PULL,
        ST_T_SNAP,
        ST_F1,
        ST_F1W,
        ST_F2,
        ST_F2W,
        ST_M_START,
        ST_M_DIV,
        ST_M_B1,
        ST_M_B2,
        ST_M_B3,
        ST_DONE
    } state_t;

    // Divider request and response.
    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    // Saturate a wide signed value to signed 32 bit.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Divide by 2^16 with truncation toward zero.
    function automatic logic signed [51:0] trunc16(input logic signed [67:0] v);
        logic signed [67:0] b;
        b = v + (v[67] ? 68'sd65535 : 68'sd0);
        return 52'(b >>> 16);
    endfunction

endpackage

/* design/idws_if.sv */
// Request and response channel interfaces of the drag tracker.
interface idws_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] time_req;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    modport source (output valid, req_type, time_req, point_x, point_y, input ready);
    modport sink (input valid, req_type, time_req, point_x, point_y, output ready);
endinterface

interface idws_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        is_free;
    modport source (output valid, pos_x, pos_y, is_free, input ready);
    modport sink (input valid, pos_x, pos_y, is_free, output ready);
endinterface

/* design/inertial_drag_with_snap.sv */
// Top level of the inertial drag tracker with grid snapping.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | req_type, time_req, point_x, point_y
//  rsp     | out | valid/ready  | pos_x, pos_y, is_free
//  cfg     | in  | cfg_we only  | cfg_index, cfg_data
//
// A free tick runs, per axis, a multiply, a modulo, pull and snap (for a
// nonzero spacing) and two friction steps; a move runs two divides. The
// serial divider and the single shared 33x33 multiplier set the duration.
// Reset clears control and tracking state and loads the register defaults.
// The response register holds a result until taken; a stalled response holds
// the sequencer in its final state and req.ready stays low.
module inertial_drag_with_snap
    import idws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    idws_req_if.sink    req,
    idws_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [15:0] friction_reg, input_accel_reg, snap_accel_reg;
    logic [11:0] spacing_x_reg, spacing_y_reg;

    logic        axis_reg, axis_next;
    logic [1:0]  type_reg, type_next;
    logic [31:0] t_reg, t_next;
    logic signed [15:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [31:0] vel_x_reg, vel_x_next, vel_y_reg, vel_y_next;
    logic [31:0] ltt_reg, ltt_next, lmt_reg, lmt_next;
    logic signed [15:0] lpx_reg, lpx_next, lpy_reg, lpy_next;
    logic        rel_reg, rel_next;
    logic [31:0] dt_reg, dt_next;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [31:0] vnew_reg, vnew_next;
    logic signed [65:0] acc_reg, acc_next;
    logic [28:0] nxt_reg, nxt_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;

    logic        out_valid_reg, out_valid_next;
    logic signed [15:0] out_x_reg, out_y_reg;
    logic        out_free_reg;
    logic        out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Per-axis views.
    logic signed [31:0] cur_pos, cur_vel, pos_w, vel_w;
    logic        wr_pos, wr_vel;
    logic [11:0] cur_spacing;
    logic signed [16:0] cur_dx;

    logic signed [67:0] step;
    logic signed [31:0] vel_pull, vnew_c;
    logic [27:0] span, rmd, mval;
    logic [28:0] nxt_c;
    logic signed [32:0] sel;
    logic [16:0] adx;
    logic [32:0] apos;

    idws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cur_pos     = axis_reg ? pos_y_reg : pos_x_reg;
    assign cur_vel     = axis_reg ? vel_y_reg : vel_x_reg;
    assign cur_spacing = axis_reg ? spacing_y_reg : spacing_x_reg;
    assign cur_dx      = axis_reg ? dy_reg : dx_reg;
    assign span        = {cur_spacing, 16'd0};
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req.valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                state_next = ST_DONE;
                if (type_reg == REQ_TICK && rel_reg)
                    state_next = ST_T_MUL;
                else if (type_reg == REQ_MOVE && t_reg != lmt_reg && lmt_reg != 32'd0)
                    state_next = ST_M_START;
            end
            ST_T_MUL:   state_next = ST_T_POS;
            ST_T_POS:   state_next = (cur_spacing != 12'd0) ? ST_T_MODST : ST_F1;
            ST_T_MODST: state_next = ST_T_DIV;
            ST_T_DIV:   if (div_rsp.done) state_next = ST_T_PULL;
            ST_T_PULL:  state_next = ST_T_SNAP;
            ST_T_SNAP:  state_next = ST_F1;
            ST_F1:      state_next = ST_F1W;
            ST_F1W:     state_next = ST_F2;
            ST_F2:      state_next = ST_F2W;
            ST_F2W:     state_next = axis_reg ? ST_DONE : ST_T_MUL;
            ST_M_START: state_next = ST_M_DIV;
            ST_M_DIV:   if (div_rsp.done) state_next = ST_M_B1;
            ST_M_B1:    state_next = ST_M_B2;
            ST_M_B2:    state_next = ST_M_B3;
            ST_M_B3:    state_next = axis_reg ? ST_DONE : ST_M_START;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath controls and next values per state.
    always_comb
    begin
        axis_next = axis_reg;
        type_next = type_reg;
        t_next    = t_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        vel_x_next = vel_x_reg;
        vel_y_next = vel_y_reg;
        ltt_next  = ltt_reg;
        lmt_next  = lmt_reg;
        lpx_next  = lpx_reg;
        lpy_next  = lpy_reg;
        rel_next  = rel_reg;
        dt_next   = dt_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        vnew_next = vnew_reg;
        acc_next  = acc_reg;
        nxt_next  = nxt_reg;
        mul_a     = '0;
        mul_b     = '0;
        div_req   = '0;
        pos_w     = cur_pos;
        vel_w     = cur_vel;
        wr_pos    = 1'b0;
        wr_vel    = 1'b0;

        step = 68'(prod_reg);
        if (step > STEP_LIMIT) step = STEP_LIMIT;
        else if (step < -STEP_LIMIT) step = -STEP_LIMIT;

        apos = cur_pos[31] ? (33'd0 - {1'b1, cur_pos}) : {1'b0, cur_pos};
        adx  = cur_dx[16] ? (17'd0 - cur_dx) : cur_dx;

        rmd   = div_rsp.rem[27:0];
        mval  = (cur_pos[31] && rmd != 28'd0) ? (span - rmd) : rmd;
        nxt_c = {1'b0, span} - {1'b0, mval};
        sel   = ({1'b0, mval} < nxt_c) ? (33'sd0 - 33'($signed({1'b0, mval})))
                                       : 33'($signed({1'b0, nxt_c}));
        vel_pull = sat32(68'(cur_vel) + 68'(trunc16(68'(prod_reg))));

        if (cur_dx[16])
            vnew_c = (div_rsp.quot > 33'h080000000) ? 32'sh80000000
                                                    : (32'd0 - div_rsp.quot[31:0]);
        else
            vnew_c = (div_rsp.quot > 33'h07FFFFFFF) ? 32'sh7FFFFFFF
                                                    : div_rsp.quot[31:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    type_next = req.req_type;
                    t_next    = req.time_req;
                    px_next   = req.point_x;
                    py_next   = req.point_y;
                end
            end
            ST_DISPATCH:
            begin
                axis_next = 1'b0;
                unique case (type_reg)
                    REQ_TICK:
                    begin
                        dt_next  = (ltt_reg == 32'd0) ? 32'd0 : (t_reg - ltt_reg);
                        ltt_next = t_reg;
                    end
                    REQ_MOVE:
                    begin
                        if (t_reg != lmt_reg)
                        begin
                            if (lmt_reg != 32'd0)
                            begin
                                dx_next = 17'(px_reg) - 17'(lpx_reg);
                                dy_next = 17'(py_reg) - 17'(lpy_reg);
                                dt_next = t_reg - lmt_reg;
                                pos_x_next = sat32(68'(pos_x_reg) + 68'(dx_next) * 68'sd65536);
                                pos_y_next = sat32(68'(pos_y_reg) + 68'(dy_next) * 68'sd65536);
                            end
                            rel_next = 1'b0;
                            lpx_next = px_reg;
                            lpy_next = py_reg;
                            lmt_next = t_reg;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        lmt_next = 32'd0;
                        rel_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_T_MUL:
            begin
                mul_a = 33'(cur_vel);
                mul_b = 33'($signed({1'b0, dt_reg}));
            end
            ST_T_POS:
            begin
                pos_w  = sat32(68'(cur_pos) + step);
                wr_pos = 1'b1;
            end
            ST_T_MODST:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = apos;
                div_req.divisor  = {4'd0, span};
            end
            ST_T_PULL:
            begin
                nxt_next = nxt_c;
                mul_a    = sel;
                mul_b    = 33'($signed({17'd0, snap_accel_reg}));
            end
            ST_T_SNAP:
            begin
                wr_vel = 1'b1;
                vel_w  = vel_pull;
                if (nxt_reg < 29'd65536 && vel_pull < SNAP_SPEED_LIMIT
                    && vel_pull > -SNAP_SPEED_LIMIT)
                begin
                    wr_pos = 1'b1;
                    pos_w  = sat32(68'(cur_pos) + 68'($signed({1'b0, nxt_reg})));
                    vel_w  = 32'sd0;
                end
            end
            ST_F1, ST_F2:
            begin
                mul_a = 33'(cur_vel);
                mul_b = 33'($signed({16'd0, ONE_Q16 - {1'b0, friction_reg}}));
            end
            ST_F1W:
            begin
                wr_vel = 1'b1;
                vel_w  = 32'(trunc16(68'(prod_reg)));
            end
            ST_F2W:
            begin
                wr_vel    = 1'b1;
                vel_w     = 32'(trunc16(68'(prod_reg)));
                axis_next = 1'b1;
            end
            ST_M_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {adx[16:0], 16'd0};
                div_req.divisor  = dt_reg;
            end
            ST_M_B1:
            begin
                vnew_next = vnew_c;
                mul_a = 33'(cur_vel);
                mul_b = 33'($signed({16'd0, ONE_Q16 - {1'b0, input_accel_reg}}));
            end
            ST_M_B2:
            begin
                acc_next = prod_reg;
                mul_a = 33'(vnew_reg);
                mul_b = 33'($signed({17'd0, input_accel_reg}));
            end
            ST_M_B3:
            begin
                wr_vel    = 1'b1;
                vel_w     = sat32(68'(trunc16(68'(acc_reg) + 68'(prod_reg))));
                axis_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (wr_pos)
        begin
            if (axis_reg) pos_y_next = pos_w;
            else pos_x_next = pos_w;
        end
        if (wr_vel)
        begin
            if (axis_reg) vel_y_next = vel_w;
            else vel_x_next = vel_w;
        end
    end

    // Response register control.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            friction_reg    <= FRICTION_RESET;
            input_accel_reg <= INPUT_ACCEL_RESET;
            snap_accel_reg  <= SNAP_ACCEL_RESET;
            spacing_x_reg   <= '0;
            spacing_y_reg   <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            vel_x_reg       <= '0;
            vel_y_reg       <= '0;
            ltt_reg         <= '0;
            lmt_reg         <= '0;
            lpx_reg         <= '0;
            lpy_reg         <= '0;
            rel_reg         <= 1'b0;
            axis_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            vel_x_reg     <= vel_x_next;
            vel_y_reg     <= vel_y_next;
            ltt_reg       <= ltt_next;
            lmt_reg       <= lmt_next;
            lpx_reg       <= lpx_next;
            lpy_reg       <= lpy_next;
            rel_reg       <= rel_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRICTION:    friction_reg    <= cfg_data;
                    CFG_INPUT_ACCEL: input_accel_reg <= cfg_data;
                    CFG_SNAP_ACCEL:  snap_accel_reg  <= cfg_data;
                    CFG_SPACING_X:   spacing_x_reg   <= cfg_data[11:0];
                    CFG_SPACING_Y:   spacing_y_reg   <= cfg_data[11:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload and work registers.
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        t_reg    <= t_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        dt_reg   <= dt_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        vnew_reg <= vnew_next;
        acc_reg  <= acc_next;
        nxt_reg  <= nxt_next;
        prod_reg <= mul_a * mul_b;
        if (out_load)
        begin
            out_x_reg    <= 16'(trunc16(68'(pos_x_reg)));
            out_y_reg    <= 16'(trunc16(68'(pos_y_reg)));
            out_free_reg <= rel_reg;
        end
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.pos_x   = out_x_reg;
    assign rsp.pos_y   = out_y_reg;
    assign rsp.is_free = out_free_reg;

endmodule

/* design/idws_div.sv */
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module idws_div
    import idws_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_sh;

    // One shift-subtract step per cycle.
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[31:0], quo_reg[32]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd33;
            rem_next  = 33'd0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg[31:0];

endmodule

/* design/idws_checker.sv */
// Port-level checker of the drag tracker, bound to the top level.
module idws_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] rsp_pos_x,
    input logic        rsp_is_free
);

    logic [1:0] inflight_reg, inflight_next;

    // Count requests taken but not yet answered; a new request may be taken
    // while the previous response still waits in the output register.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_valid && req_ready && !(rsp_valid && rsp_ready))
            inflight_next = inflight_reg + 2'd1;
        else if (!(req_valid && req_ready) && rsp_valid && rsp_ready)
            inflight_next = inflight_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 2'd0;
        else
            inflight_reg <= inflight_next;
    end

    // A stalled response stays valid and keeps its x position.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x))
        else $error("stalled response changed");

    // A stalled response keeps its free flag.
    a_free_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_is_free))
        else $error("stalled free flag changed");

    // With one response waiting and one request in work, no request is taken.
    a_two_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 2'd2 |-> !req_ready)
        else $error("request accepted while busy");

    // A response only appears for an accepted request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> inflight_reg != 2'd0)
        else $error("response without request");

endmodule

bind inertial_drag_with_snap idws_checker u_idws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_pos_x   (rsp.pos_x),
    .rsp_is_free (rsp.is_free)
);
